>>> src/zcdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcdp_pkg
// Types and constants shared by the central directory parser modules.
// ----------------------------------------------------------------------------
package zcdp_pkg;

    localparam logic [31:0] CENTRAL_SIGNATURE = 32'h0201_4b50;
    localparam logic [17:0] HEADER_BYTES      = 18'd46;
    localparam logic [15:0] METHOD_STORED     = 16'd0;
    localparam logic [15:0] METHOD_DEFLATE    = 16'd8;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTORY_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRIES_CLAIMED = 2'd1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        KIND_NAME   = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_TOO_MANY_ENTRIES = 3'd0,
        ERR_HEADER_PAST_END  = 3'd1,
        ERR_BAD_SIGNATURE    = 3'd2,
        ERR_NAMES_PAST_END   = 3'd3,
        ERR_ENCRYPTED        = 3'd4,
        ERR_BAD_METHOD       = 3'd5
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  error_code;
        logic [7:0]  name_byte;
        logic        deflated;
        logic [31:0] compressed_size;
        logic [31:0] uncompressed_size;
        logic [15:0] name_length;
        logic [31:0] local_offset;
        logic [8:0]  entry_index;
        logic        last_entry;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage
`default_nettype wire

>>> src/zcdp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcdp_fifo
// Small result queue: takes up to two results a cycle, gives one a transfer.
// ----------------------------------------------------------------------------
module zcdp_fifo
    import zcdp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_push   i_push,
    output logic         o_room,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    t_result                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wptr;
    logic [FIFO_PTR_W-1:0]   r_rptr;
    logic [FIFO_PTR_W:0]     r_count;
    logic [FIFO_PTR_W-1:0]   n_wptr;
    logic [FIFO_PTR_W-1:0]   w_wptr1;
    logic [FIFO_PTR_W:0]     n_count;
    logic                    w_pop;

    assign w_pop   = (r_count != '0) && i_ready;
    assign w_wptr1 = r_wptr + FIFO_PTR_W'(1);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_room  = (r_count <= (FIFO_PTR_W + 1)'(FIFO_DEPTH - 2));

    always_comb begin
        n_wptr  = r_wptr + FIFO_PTR_W'(i_push.count);
        n_count = r_count + (FIFO_PTR_W + 1)'(i_push.count)
                  - (FIFO_PTR_W + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wptr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_count <= n_count;
            if (w_pop) begin
                r_rptr <= r_rptr + FIFO_PTR_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> src/zcdp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcdp_core
// Configuration registers, header field capture and entry checks, one byte
// a cycle while i_accept is high.
// ----------------------------------------------------------------------------
module zcdp_core
    import zcdp_pkg::*;
#(
    parameter int MAX_ENTRIES = 512
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [31:0]            i_cfg_data,
    input  wire logic                   i_accept,
    input  wire logic [7:0]             i_dir_byte,
    output t_push                       o_push
);

    localparam int DONE_W = $clog2(MAX_ENTRIES + 1);

    logic [31:0]       r_directory_size;
    logic [15:0]       r_entries_claimed;
    logic [31:0]       r_dir_pos;
    logic [17:0]       r_entry_pos;
    logic [DONE_W-1:0] r_entries_done;
    logic              r_halted;
    logic [31:0]       r_sig;
    logic              r_encrypted;
    logic [15:0]       r_method;
    logic [31:0]       r_csize;
    logic [31:0]       r_usize;
    logic [15:0]       r_name_len;
    logic [15:0]       r_extra_len;
    logic [15:0]       r_comment_len;
    logic [31:0]       r_offset;

    logic [31:0]       n_dir_pos;
    logic [17:0]       n_entry_pos;
    logic [DONE_W-1:0] n_entries_done;
    logic              n_halted;
    logic [31:0]       n_sig;
    logic              n_encrypted;
    logic [15:0]       n_method;
    logic [31:0]       n_csize;
    logic [31:0]       n_usize;
    logic [15:0]       n_name_len;
    logic [15:0]       n_extra_len;
    logic [15:0]       n_comment_len;
    logic [31:0]       n_offset;

    logic              w_first;
    logic [17:0]       w_total;
    logic              w_too_many;
    logic              w_all_done;
    logic              w_hdr_past;
    logic              w_sig_bad;
    logic              w_last_hdr;
    logic              w_names_past;
    logic              w_method_bad;
    logic              w_name_out;
    logic              w_rec_out;
    logic              w_entry_end;
    logic              w_update;
    t_result           w_name;
    t_result           w_rec;
    t_result           w_err;

    assign w_first = (r_entry_pos == '0);

    // capture header fields; the first byte of an entry starts from cleared fields
    always_comb begin
        n_sig         = w_first ? '0 : r_sig;
        n_encrypted   = w_first ? 1'b0 : r_encrypted;
        n_method      = w_first ? '0 : r_method;
        n_csize       = w_first ? '0 : r_csize;
        n_usize       = w_first ? '0 : r_usize;
        n_name_len    = w_first ? '0 : r_name_len;
        n_extra_len   = w_first ? '0 : r_extra_len;
        n_comment_len = w_first ? '0 : r_comment_len;
        n_offset      = w_first ? '0 : r_offset;
        case (r_entry_pos) inside
            [18'd0:18'd3]: n_sig = {i_dir_byte, n_sig[31:8]};
            18'd8:  n_encrypted         = i_dir_byte[0];
            18'd10: n_method[7:0]       = i_dir_byte;
            18'd11: n_method[15:8]      = i_dir_byte;
            18'd20: n_csize[7:0]        = i_dir_byte;
            18'd21: n_csize[15:8]       = i_dir_byte;
            18'd22: n_csize[23:16]      = i_dir_byte;
            18'd23: n_csize[31:24]      = i_dir_byte;
            18'd24: n_usize[7:0]        = i_dir_byte;
            18'd25: n_usize[15:8]       = i_dir_byte;
            18'd26: n_usize[23:16]      = i_dir_byte;
            18'd27: n_usize[31:24]      = i_dir_byte;
            18'd28: n_name_len[7:0]     = i_dir_byte;
            18'd29: n_name_len[15:8]    = i_dir_byte;
            18'd30: n_extra_len[7:0]    = i_dir_byte;
            18'd31: n_extra_len[15:8]   = i_dir_byte;
            18'd32: n_comment_len[7:0]  = i_dir_byte;
            18'd33: n_comment_len[15:8] = i_dir_byte;
            18'd42: n_offset[7:0]       = i_dir_byte;
            18'd43: n_offset[15:8]      = i_dir_byte;
            18'd44: n_offset[23:16]     = i_dir_byte;
            18'd45: n_offset[31:24]     = i_dir_byte;
            default: ;
        endcase
    end

    always_comb begin
        w_total      = HEADER_BYTES + 18'(n_name_len) + 18'(n_extra_len)
                       + 18'(n_comment_len);
        w_too_many   = {1'b0, r_entries_claimed} > 17'(MAX_ENTRIES);
        w_all_done   = 17'(r_entries_done) >= {1'b0, r_entries_claimed};
        w_hdr_past   = w_first
                       && ((33'(r_dir_pos) + 33'(HEADER_BYTES)) > 33'(r_directory_size));
        w_sig_bad    = (r_entry_pos == 18'd3) && (n_sig != CENTRAL_SIGNATURE);
        w_last_hdr   = (r_entry_pos == HEADER_BYTES - 18'd1);
        w_names_past = w_last_hdr
                       && ((34'(r_dir_pos) + 34'd1 + 34'(n_name_len) + 34'(n_extra_len)
                            + 34'(n_comment_len)) > 34'(r_directory_size));
        w_method_bad = w_last_hdr && (n_method != METHOD_STORED)
                       && (n_method != METHOD_DEFLATE);
        w_name_out   = (r_entry_pos >= HEADER_BYTES)
                       && (19'(r_entry_pos) < (19'(HEADER_BYTES) + 19'(n_name_len)));
        w_rec_out    = 19'(r_entry_pos) == (19'(HEADER_BYTES) - 19'd1 + 19'(n_name_len));
        w_entry_end  = (19'(r_entry_pos) + 19'd1) >= 19'(w_total);
    end

    always_comb begin
        w_name           = '0;
        w_name.kind      = KIND_NAME;
        w_name.name_byte = i_dir_byte;

        w_rec                   = '0;
        w_rec.kind              = KIND_RECORD;
        w_rec.deflated          = (n_method == METHOD_DEFLATE);
        w_rec.compressed_size   = n_csize;
        w_rec.uncompressed_size = n_usize;
        w_rec.name_length       = n_name_len;
        w_rec.local_offset      = n_offset;
        w_rec.entry_index       = 9'(r_entries_done);
        w_rec.last_entry        = (17'(r_entries_done) + 17'd1) == {1'b0, r_entries_claimed};

        w_err      = '0;
        w_err.kind = KIND_ERROR;
        w_update   = 1'b0;
        o_push     = '0;
        if (i_accept && !r_halted) begin
            if (w_too_many) begin
                w_err.error_code = ERR_TOO_MANY_ENTRIES;
            end else if (w_all_done) begin
                w_err.error_code = ERR_TOO_MANY_ENTRIES;
            end else if (w_hdr_past) begin
                w_err.error_code = ERR_HEADER_PAST_END;
            end else if (w_sig_bad) begin
                w_err.error_code = ERR_BAD_SIGNATURE;
            end else if (w_names_past) begin
                w_err.error_code = ERR_NAMES_PAST_END;
            end else if (w_last_hdr && n_encrypted) begin
                w_err.error_code = ERR_ENCRYPTED;
            end else if (w_method_bad) begin
                w_err.error_code = ERR_BAD_METHOD;
            end else begin
                w_update = 1'b1;
            end

            if (w_update) begin
                if (w_name_out && w_rec_out) begin
                    o_push.count = 2'd2;
                    o_push.res0  = w_name;
                    o_push.res1  = w_rec;
                end else if (w_name_out) begin
                    o_push.count = 2'd1;
                    o_push.res0  = w_name;
                end else if (w_rec_out) begin
                    o_push.count = 2'd1;
                    o_push.res0  = w_rec;
                end
            end else if (!w_all_done || w_too_many) begin
                o_push.count = 2'd1;
                o_push.res0  = w_err;
            end
        end
    end

    always_comb begin
        n_halted       = r_halted;
        n_dir_pos      = r_dir_pos;
        n_entry_pos    = r_entry_pos;
        n_entries_done = r_entries_done;
        if (i_accept && !r_halted && (o_push.count != 2'd0)
            && (o_push.res0.kind == KIND_ERROR)) begin
            n_halted = 1'b1;
        end
        if (w_update) begin
            n_dir_pos = r_dir_pos + 32'd1;
            if (w_entry_end) begin
                n_entry_pos    = '0;
                n_entries_done = r_entries_done + DONE_W'(1);
            end else begin
                n_entry_pos = r_entry_pos + 18'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_sig         <= n_sig;
            r_encrypted   <= n_encrypted;
            r_method      <= n_method;
            r_csize       <= n_csize;
            r_usize       <= n_usize;
            r_name_len    <= n_name_len;
            r_extra_len   <= n_extra_len;
            r_comment_len <= n_comment_len;
            r_offset      <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_directory_size  <= '0;
            r_entries_claimed <= '0;
            r_dir_pos         <= '0;
            r_entry_pos       <= '0;
            r_entries_done    <= '0;
            r_halted          <= 1'b0;
        end else begin
            r_dir_pos      <= n_dir_pos;
            r_entry_pos    <= n_entry_pos;
            r_entries_done <= n_entries_done;
            r_halted       <= n_halted;
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_DIRECTORY_SIZE:  r_directory_size  <= i_cfg_data;
                    CFG_ENTRIES_CLAIMED: r_entries_claimed <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

>>> src/zip_central_directory_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zip_central_directory_parser_top
// Checks the entries of a zip central directory streamed one byte a transfer.
//
// Configuration: write directory_size (index 0) and entries_claimed (index 1)
// on the cfg channel while the block is idle; cfg ready is always high.
// Input: one directory byte per transfer on i_valid / o_ready, in file order.
// Output: one result per transfer on o_valid / i_ready: name bytes, then one
// entry record, or a single error after which the block stays silent.
// Result path: results are registered in the result queue and offered from it in order.
// Throughput: one byte a cycle. The last name byte of an entry yields two
// results; a four-entry result queue absorbs them and o_ready drops only when
// fewer than two places are free.
// Receiver stall: results wait in the queue; input is held off once fewer than two places are free.
// Reset: synchronous, active low; clears position, entry count, halt flag,
// the queue and both configuration registers.
// ----------------------------------------------------------------------------
module zip_central_directory_parser_top
    import zcdp_pkg::*;
#(
    parameter int MAX_ENTRIES = 512
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [31:0]            i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [7:0]             i_dir_byte,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [1:0]                  o_result_kind,
    output logic [2:0]                  o_error_code,
    output logic [7:0]                  o_name_byte,
    output logic                        o_deflated,
    output logic [31:0]                 o_compressed_size,
    output logic [31:0]                 o_uncompressed_size,
    output logic [15:0]                 o_name_length,
    output logic [31:0]                 o_local_offset,
    output logic [8:0]                  o_entry_index,
    output logic                        o_last_entry
);

    logic    w_accept;
    logic    w_room;
    t_push   w_push;
    t_result w_out;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = w_room;
    assign w_accept    = i_valid && w_room;

    zcdp_core #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_dir_byte  (i_dir_byte),
        .o_push      (w_push)
    );

    zcdp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out)
    );

    assign o_result_kind       = w_out.kind;
    assign o_error_code        = w_out.error_code;
    assign o_name_byte         = w_out.name_byte;
    assign o_deflated          = w_out.deflated;
    assign o_compressed_size   = w_out.compressed_size;
    assign o_uncompressed_size = w_out.uncompressed_size;
    assign o_name_length       = w_out.name_length;
    assign o_local_offset      = w_out.local_offset;
    assign o_entry_index       = w_out.entry_index;
    assign o_last_entry        = w_out.last_entry;

    a_push_needs_transfer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count != 2'd0) |-> w_accept)
        else $error("results pushed without an input transfer");

    a_pair_is_name_then_record : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count == 2'd2) |->
            (w_push.res0.kind == KIND_NAME) && (w_push.res1.kind == KIND_RECORD))
        else $error("double push is not last name byte followed by record");

    a_silent_after_error : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_push.count != 2'd0) && (w_push.res0.kind == KIND_ERROR))
            |=> (w_push.count == 2'd0))
        else $error("result pushed after an error");

endmodule
`default_nettype wire
